// ----- src/vzrd_pkg.sv -----
// Shared types and constants for the visibility zero-run decoder.
`default_nettype none

package vzrd_pkg;

  // Field widths
  localparam int LEAF_W     = 14;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 64;
  localparam int VB_W       = 4;
  localparam int WIDX_W     = 7;
  localparam int M_TDATA_W  = 80;
  localparam int BYTES_PER_WORD = 8;

  // Defaults
  localparam int MAX_LEAVES_DEF = 8192;
  localparam logic [LEAF_W-1:0] LEAF_COUNT_RST = LEAF_W'(8192);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_LEAF_COUNT = '0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_RUN
  } vzrd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic lit;    // push the input byte as a literal
    logic load;   // load the zero-run count from the input byte
    logic step;   // push one chunk of the pending zero run
  } vzrd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic byte_zero;  // input byte is zero
    logic run_last;   // this run step finishes the run
    logic slot_free;  // output register can take a word
  } vzrd_stat_t;

endpackage

`default_nettype wire

// ----- src/vzrd_regs.sv -----
// Configuration register file and row length derivation.
`default_nettype none

module vzrd_regs #(
  parameter int MAX_LEAVES = vzrd_pkg::MAX_LEAVES_DEF,
  parameter int RB_W = $clog2((MAX_LEAVES + 7) / 8 + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vzrd_pkg::APB_AW-1:0] paddr,
  input  wire logic [vzrd_pkg::APB_DW-1:0] pwdata,
  output logic      [vzrd_pkg::APB_DW-1:0] prdata,
  output logic      [RB_W-1:0]             row_bytes
);

  localparam int LOG_N = $clog2(MAX_LEAVES + 8);
  localparam int NW = (LOG_N > vzrd_pkg::LEAF_W ? LOG_N : vzrd_pkg::LEAF_W) + 1;

  logic [vzrd_pkg::LEAF_W-1:0] leaf_count;
  logic                        reg_hit;
  logic [NW-1:0]               leaves;
  logic [NW-1:0]               leaves_up;

  assign reg_hit = (paddr[vzrd_pkg::APB_AW-1:2] == vzrd_pkg::REG_LEAF_COUNT);

  // Write the leaf count register
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= vzrd_pkg::LEAF_COUNT_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      leaf_count <= pwdata[vzrd_pkg::LEAF_W-1:0];
    end
  end

  // Read back
  assign prdata = reg_hit ? vzrd_pkg::APB_DW'(leaf_count) : '0;

  // Clamp the leaf count and round up to whole bytes
  always_comb begin
    leaves = NW'(leaf_count);
    if (leaves == '0) begin
      leaves = NW'(1);
    end else if (leaves > NW'(MAX_LEAVES)) begin
      leaves = NW'(MAX_LEAVES);
    end
    leaves_up = leaves + NW'(7);
    row_bytes = RB_W'(leaves_up >> 3);
  end

endmodule

`default_nettype wire

// ----- src/vzrd_ctrl.sv -----
// Controller state machine: sequences literals, markers and zero runs.
`default_nettype none

module vzrd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire vzrd_pkg::vzrd_stat_t stat,
  output vzrd_pkg::vzrd_cmd_t      cmd
);

  vzrd_pkg::vzrd_state_t state;
  vzrd_pkg::vzrd_state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vzrd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decide next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      vzrd_pkg::ST_IDLE: begin
        s_tready = stat.slot_free;
        if (s_tvalid && stat.slot_free) begin
          if (stat.byte_zero) begin
            state_next = vzrd_pkg::ST_MARK;
          end else begin
            cmd.lit = 1'b1;
          end
        end
      end
      vzrd_pkg::ST_MARK: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = stat.byte_zero ? vzrd_pkg::ST_IDLE : vzrd_pkg::ST_RUN;
        end
      end
      vzrd_pkg::ST_RUN: begin
        if (stat.slot_free) begin
          cmd.step = 1'b1;
          if (stat.run_last) begin
            state_next = vzrd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = vzrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/vzrd_dp.sv -----
// Datapath: byte packing, row tracking, zero-run counter and output register.
`default_nettype none

module vzrd_dp #(
  parameter int RB_W = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [vzrd_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic [RB_W-1:0]                row_bytes,
  input  wire vzrd_pkg::vzrd_cmd_t            cmd,
  output vzrd_pkg::vzrd_stat_t                stat,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [vzrd_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tlast
);

  localparam int CW = (RB_W > vzrd_pkg::BYTE_W) ? RB_W : vzrd_pkg::BYTE_W;

  logic [vzrd_pkg::WORD_W-1:0] pack_word;
  logic [2:0]                  pack_count;
  logic [RB_W-1:0]             row_position;
  logic [vzrd_pkg::BYTE_W-1:0] zeros_pending;
  logic [vzrd_pkg::WIDX_W-1:0] out_word_index;

  logic [vzrd_pkg::WORD_W-1:0] word_next;
  logic [vzrd_pkg::VB_W-1:0]   room_word;
  logic [CW-1:0]               room_row;
  logic [CW-1:0]               run_k;
  logic [vzrd_pkg::VB_W-1:0]   k;
  logic [RB_W:0]               pos_sum;
  logic [vzrd_pkg::VB_W-1:0]   filled;
  logic                        row_end;
  logic                        full;
  logic                        push;
  logic                        emit;

  // Size the chunk: bounded by the pending zeros, the word and the row
  always_comb begin
    room_word = vzrd_pkg::VB_W'(vzrd_pkg::BYTES_PER_WORD) - vzrd_pkg::VB_W'(pack_count);
    if (row_position >= row_bytes) begin
      room_row = CW'(1);
    end else begin
      room_row = CW'(row_bytes - row_position);
    end
    run_k = CW'(zeros_pending);
    if (CW'(room_word) < run_k) begin
      run_k = CW'(room_word);
    end
    if (room_row < run_k) begin
      run_k = room_row;
    end
    k = cmd.lit ? vzrd_pkg::VB_W'(1) : vzrd_pkg::VB_W'(run_k);
  end

  // Place the byte and check word and row ends
  always_comb begin
    word_next = pack_word;
    if (cmd.lit) begin
      word_next = pack_word |
                  (vzrd_pkg::WORD_W'(in_byte) << {pack_count, 3'b000});
    end
    pos_sum = (RB_W + 1)'(row_position) + (RB_W + 1)'(k);
    filled  = vzrd_pkg::VB_W'(pack_count) + k;
    row_end = (pos_sum >= (RB_W + 1)'(row_bytes));
    full    = (filled == vzrd_pkg::VB_W'(vzrd_pkg::BYTES_PER_WORD));
    push    = cmd.lit || cmd.step;
    emit    = push && (row_end || full);
  end

  // Report status; a chunk that fills the rest of the row or uses the last pending zeros ends the run
  always_comb begin
    stat.byte_zero = (in_byte == '0);
    stat.run_last  = (run_k == room_row) || (CW'(zeros_pending) == run_k);
    stat.slot_free = !m_tvalid || m_tready;
  end

  // Advance packing and row state
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_word      <= '0;
      pack_count     <= '0;
      row_position   <= '0;
      zeros_pending  <= '0;
      out_word_index <= '0;
    end else begin
      if (cmd.load) begin
        zeros_pending <= in_byte;
      end else if (cmd.step) begin
        zeros_pending <= row_end ? '0 : zeros_pending - vzrd_pkg::BYTE_W'(k);
      end
      if (push) begin
        if (emit) begin
          pack_word  <= '0;
          pack_count <= '0;
          if (row_end) begin
            row_position   <= '0;
            out_word_index <= '0;
          end else begin
            row_position   <= RB_W'(pos_sum);
            out_word_index <= out_word_index + vzrd_pkg::WIDX_W'(1);
          end
        end else begin
          pack_word    <= word_next;
          pack_count   <= filled[2:0];
          row_position <= RB_W'(pos_sum);
        end
      end
    end
  end

  // Hold the finished word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {5'b00000, out_word_index, filled, word_next};
      m_tlast <= row_end;
    end
  end

endmodule

`default_nettype wire

// ----- src/vis_zero_run_decoder.sv -----
// A literal byte that completes a word shows it on the output in the cycle after it is accepted.
// Literal bytes and markers are taken straight from the input; a run count is loaded and then
// filled with one zero-fill step in the datapath per output word the run touches.
// Literals and markers are held off while a finished word waits and the output is stalled.
// Reset (rst, synchronous, active high) clears control state and sets leaf_count to 8192.
`default_nettype none

module vis_zero_run_decoder #(
  parameter int MAX_LEAVES = vzrd_pkg::MAX_LEAVES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vzrd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [vzrd_pkg::APB_DW-1:0]    pwdata,
  output logic      [vzrd_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  // Compressed input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [vzrd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] vis_byte
  // Decoded output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [vzrd_pkg::M_TDATA_W-1:0]      m_tdata,   // [63:0] vis_word, [67:64] valid_bytes,
                                                         // [74:68] word_index, [79:75] zero
  output logic                                m_tlast    // row_last
);

  localparam int RB_W = $clog2((MAX_LEAVES + 7) / 8 + 1);

  logic [RB_W-1:0]      row_bytes;
  vzrd_pkg::vzrd_cmd_t  cmd;
  vzrd_pkg::vzrd_stat_t stat;

  assign pready = 1'b1;

  vzrd_regs #(
    .MAX_LEAVES (MAX_LEAVES),
    .RB_W       (RB_W)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .row_bytes (row_bytes)
  );

  vzrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vzrd_dp #(
    .RB_W (RB_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .row_bytes (row_bytes),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // A word that does not end the row is always full
  a_full_mid_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'd8)
    else $error("partial word before row end");

  // Byte count of a shown word is one to eight
  a_vb_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8))
    else $error("valid_bytes out of range");

  // No literal or run step is pushed while a word waits behind a stalled output
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && (cmd.lit || cmd.step) |-> 1'b0)
    else $error("word pushed over a stalled output");

  // A nonzero run count blocks input on the next cycle
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.load && (s_tdata != '0) |=> !s_tready)
    else $error("input taken during a zero run");

endmodule

`default_nettype wire
